// File: design/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg: shared constants for the matrix vector transform
// Matrix shape, bus field width and register indexes of the matrix bank.
// ----------------------------------------------------------------------------
package mvt_pkg;

   // matrix shape
   localparam int NUM_ROWS  = 4;
   localparam int NUM_COLS  = 4;

   // width of one field on the request and response buses
   localparam int FIELD_W   = 32;

   // matrix register bank
   localparam int REG_COUNT = 8;
   localparam int REG_IDX_W = 3;
   localparam int REG_W     = 64;

   // register indexes, two elements per register
   typedef enum logic [REG_IDX_W-1:0] {
      REG_ROW0_COLS01 = 3'd0,
      REG_ROW0_COLS23 = 3'd1,
      REG_ROW1_COLS01 = 3'd2,
      REG_ROW1_COLS23 = 3'd3,
      REG_ROW2_COLS01 = 3'd4,
      REG_ROW2_COLS23 = 3'd5,
      REG_ROW3_COLS01 = 3'd6,
      REG_ROW3_COLS23 = 3'd7
   } reg_idx_type;

endpackage

// File: design/mvt_cell.sv
// ----------------------------------------------------------------------------
// mvt_cell: one column cell of the transform chain
// Multiplies its vector component by the four row elements of its column,
// then adds the products to the partial row sums handed in by the previous
// cell. Two register stages, each with its own valid and stall control.
// ----------------------------------------------------------------------------
module mvt_cell
   import mvt_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int COL        = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [DATA_WIDTH-1:0] in_vec [NUM_COLS],
   input  logic signed [2*DATA_WIDTH+1:0] in_sum [NUM_ROWS],
   input  logic signed [DATA_WIDTH-1:0] elem [NUM_ROWS],
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [DATA_WIDTH-1:0] out_vec [NUM_COLS],
   output logic signed [2*DATA_WIDTH+1:0] out_sum [NUM_ROWS]
);

   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int SUM_W  = 2 * DATA_WIDTH + 2;

   // multiply stage
   logic                       mul_valid_ff;
   logic signed [DATA_WIDTH-1:0] mul_vec_ff [NUM_COLS];
   logic signed [SUM_W-1:0]    mul_sum_ff [NUM_ROWS];
   logic signed [PROD_W-1:0]   prod_ff [NUM_ROWS];
   logic signed [PROD_W-1:0]   prod_in [NUM_ROWS];

   // accumulate stage
   logic                       acc_valid_ff;
   logic signed [DATA_WIDTH-1:0] acc_vec_ff [NUM_COLS];
   logic signed [SUM_W-1:0]    acc_sum_ff [NUM_ROWS];
   logic signed [SUM_W-1:0]    acc_sum_in [NUM_ROWS];

   logic mul_en;
   logic acc_en;

   // stall control: a stage moves when it is empty or its successor moves
   assign acc_en   = !acc_valid_ff || out_ready;
   assign mul_en   = !mul_valid_ff || acc_en;
   assign in_ready = mul_en;

   // column products
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         prod_in[r] = PROD_W'(elem[r]) * PROD_W'(in_vec[COL]);
      end
   end

   // partial sums
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         acc_sum_in[r] = mul_sum_ff[r] + SUM_W'(prod_ff[r]);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         acc_valid_ff <= 1'b0;
      end else begin
         if (mul_en) begin
            mul_valid_ff <= in_valid;
         end
         if (acc_en) begin
            acc_valid_ff <= mul_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (mul_en) begin
         mul_vec_ff <= in_vec;
         mul_sum_ff <= in_sum;
         prod_ff    <= prod_in;
      end
      if (acc_en) begin
         acc_vec_ff <= mul_vec_ff;
         acc_sum_ff <= acc_sum_in;
      end
   end

   assign out_valid = acc_valid_ff;
   assign out_vec   = acc_vec_ff;
   assign out_sum   = acc_sum_ff;

endmodule

// File: design/mvt_sat.sv
// ----------------------------------------------------------------------------
// mvt_sat: scale, clip and output register
// Shifts each full-width row sum right by the fraction bits (floor), clips it
// to the signed data range and holds the response until it is taken.
// ----------------------------------------------------------------------------
module mvt_sat
   import mvt_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [2*DATA_WIDTH+1:0] in_sum [NUM_ROWS],
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [NUM_ROWS*FIELD_W-1:0]  rsp_tdata,
   output logic                         rsp_tuser
);

   localparam int SUM_W = 2 * DATA_WIDTH + 2;
   localparam int EXT_W = (SUM_W > DATA_WIDTH) ? SUM_W : DATA_WIDTH + 1;

   localparam logic signed [EXT_W-1:0] MAX_V =
      {{(EXT_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [EXT_W-1:0] MIN_V =
      {{(EXT_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   logic                        valid_ff;
   logic [NUM_ROWS*FIELD_W-1:0] data_ff;
   logic [NUM_ROWS*FIELD_W-1:0] data_in;
   logic                        sat_ff;
   logic                        sat_in;
   logic                        load;

   logic signed [EXT_W-1:0]      shifted [NUM_ROWS];
   logic signed [DATA_WIDTH-1:0] clipped [NUM_ROWS];

   assign in_ready = !valid_ff || rsp_tready;
   assign load     = in_valid && in_ready;

   // floor shift, clip and sign-extend to the bus field
   always_comb begin
      sat_in = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         shifted[r] = EXT_W'(in_sum[r]) >>> FRAC_BITS;
         if (shifted[r] > MAX_V) begin
            clipped[r] = MAX_V[DATA_WIDTH-1:0];
            sat_in     = 1'b1;
         end else if (shifted[r] < MIN_V) begin
            clipped[r] = MIN_V[DATA_WIDTH-1:0];
            sat_in     = 1'b1;
         end else begin
            clipped[r] = shifted[r][DATA_WIDTH-1:0];
         end
         data_in[r*FIELD_W +: FIELD_W] = FIELD_W'(clipped[r]);
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = sat_ff;

endmodule

// File: design/matrix_vector_transform.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform: 4x4 fixed-point matrix times vector
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata: vec_x, vec_y, vec_z, vec_w
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: out_x..out_w, tuser: saturated
//   csr_     in   csr_we                 csr_addr: register, csr_wdata
//
// One request per cycle while the chain is not stalled, one response per
// request. Four column cells of two stages each (multiply, accumulate), then
// the clip and output register. Each stage stalls only when full and its
// successor is stalled, so gaps close up behind a stalled response.
// Synchronous reset empties the chain and loads the identity matrix.
// ----------------------------------------------------------------------------
module matrix_vector_transform
   import mvt_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [NUM_COLS*FIELD_W-1:0] req_tdata,  // vec_x, vec_y, vec_z, vec_w
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [NUM_ROWS*FIELD_W-1:0] rsp_tdata,  // out_x, out_y, out_z, out_w
   output logic                        rsp_tuser,  // saturated
   // matrix registers
   input  logic                        csr_we,
   input  logic [REG_IDX_W-1:0]        csr_addr,
   input  logic [REG_W-1:0]            csr_wdata
);

   localparam int SUM_W = 2 * DATA_WIDTH + 2;
   localparam logic [FIELD_W-1:0] ONE_Q = FIELD_W'(64'd1 << FRAC_BITS);

   logic [REG_W-1:0] mat_ff [REG_COUNT];

   logic                         chain_valid [NUM_COLS+1];
   logic                         chain_ready [NUM_COLS+1];
   logic signed [DATA_WIDTH-1:0] chain_vec [NUM_COLS+1][NUM_COLS];
   logic signed [SUM_W-1:0]      chain_sum [NUM_COLS+1][NUM_ROWS];
   logic signed [DATA_WIDTH-1:0] col_elem [NUM_COLS][NUM_ROWS];

   // matrix registers, identity after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[REG_ROW0_COLS01] <= {{FIELD_W{1'b0}}, ONE_Q};
         mat_ff[REG_ROW0_COLS23] <= '0;
         mat_ff[REG_ROW1_COLS01] <= {ONE_Q, {FIELD_W{1'b0}}};
         mat_ff[REG_ROW1_COLS23] <= '0;
         mat_ff[REG_ROW2_COLS01] <= '0;
         mat_ff[REG_ROW2_COLS23] <= {{FIELD_W{1'b0}}, ONE_Q};
         mat_ff[REG_ROW3_COLS01] <= '0;
         mat_ff[REG_ROW3_COLS23] <= {ONE_Q, {FIELD_W{1'b0}}};
      end else if (csr_we) begin
         mat_ff[csr_addr] <= csr_wdata;
      end
   end

   // column elements for each cell
   always_comb begin
      for (int c = 0; c < NUM_COLS; c++) begin
         for (int r = 0; r < NUM_ROWS; r++) begin
            col_elem[c][r] =
               mat_ff[r*2 + c/2][(c%2)*FIELD_W +: DATA_WIDTH];
         end
      end
   end

   // request into the head of the chain
   always_comb begin
      chain_valid[0] = req_tvalid;
      req_tready     = chain_ready[0];
      for (int c = 0; c < NUM_COLS; c++) begin
         chain_vec[0][c] = req_tdata[c*FIELD_W +: DATA_WIDTH];
      end
      for (int r = 0; r < NUM_ROWS; r++) begin
         chain_sum[0][r] = '0;
      end
   end

   // column cells
   for (genvar c = 0; c < NUM_COLS; c++) begin : g_cell
      mvt_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .COL        (c)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[c]),
         .in_ready  (chain_ready[c]),
         .in_vec    (chain_vec[c]),
         .in_sum    (chain_sum[c]),
         .elem      (col_elem[c]),
         .out_valid (chain_valid[c+1]),
         .out_ready (chain_ready[c+1]),
         .out_vec   (chain_vec[c+1]),
         .out_sum   (chain_sum[c+1])
      );
   end

   // scale, clip and response register
   mvt_sat #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_sat (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[NUM_COLS]),
      .in_ready   (chain_ready[NUM_COLS]),
      .in_sum     (chain_sum[NUM_COLS]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: design/mvt_checker.sv
// ----------------------------------------------------------------------------
// mvt_checker: port-level checks for the matrix vector transform
// Watches the response channel for hold, reset and range behavior.
// ----------------------------------------------------------------------------
module mvt_checker
   import mvt_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [NUM_ROWS*FIELD_W-1:0] rsp_tdata,
   input logic                        rsp_tuser
);

   localparam logic [FIELD_W-1:0] MAX_Q = FIELD_W'((64'd1 << (DATA_WIDTH-1)) - 1);
   localparam logic [FIELD_W-1:0] MIN_Q = ~MAX_Q;

   logic [NUM_ROWS-1:0] at_limit;
   logic [NUM_ROWS-1:0] in_range;

   // per-component limit and sign-extension checks
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         at_limit[r] = (rsp_tdata[r*FIELD_W +: FIELD_W] == MAX_Q) ||
                       (rsp_tdata[r*FIELD_W +: FIELD_W] == MIN_Q);
         in_range[r] = (rsp_tdata[r*FIELD_W+DATA_WIDTH-1 +: 1] == 1'b0 &&
                        rsp_tdata[r*FIELD_W +: FIELD_W] <= MAX_Q) ||
                       (rsp_tdata[r*FIELD_W+DATA_WIDTH-1 +: 1] == 1'b1 &&
                        rsp_tdata[r*FIELD_W +: FIELD_W] >= MIN_Q);
      end
   end

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // reset empties the chain
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // the saturation flag needs a component clipped to a limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> at_limit != '0)
      else $error("saturation flag without a clipped component");

   // every component is a sign-extended data-width value
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> &in_range)
      else $error("response component outside the data range");

endmodule

bind matrix_vector_transform mvt_checker #(.DATA_WIDTH(DATA_WIDTH)) u_mvt_checker (.*);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: matrix vector transform testbench
// Streams vectors through the 4x4 fixed-point transform under several matrix
// settings, with random gaps on both channels and one long response hold.
// Every response is checked against a predictor that sums the four products
// at full width, floors the fraction away and clips to 32 bits.
// ----------------------------------------------------------------------------
module tb_top
   import mvt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_WIDTH      = 32;
   localparam int FRAC_BITS       = 16;
   localparam int LATENCY         = 9;
   localparam int HOLD_CYCLES     = 80;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 88;
   localparam int HOLD_PHASE      = 2;
   localparam int HOLD_AT_ITEM    = 30;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SUM_W           = 2*FIELD_W + 4;

   localparam logic signed [SUM_W-1:0] COMP_MAX = (SUM_W'(1) <<< (FIELD_W-1)) - 1;
   localparam logic signed [SUM_W-1:0] COMP_MIN = -(SUM_W'(1) <<< (FIELD_W-1));

   localparam logic [FIELD_W-1:0] FIELD_MAX = 32'h7FFF_FFFF;
   localparam logic [FIELD_W-1:0] FIELD_MIN = 32'h8000_0000;
   localparam logic [FIELD_W-1:0] Q_ONE     = 32'h0001_0000;
   localparam logic [FIELD_W-1:0] Q_TWO     = 32'h0002_0000;
   localparam logic [FIELD_W-1:0] Q_HALF    = 32'h0000_8000;

   // vector x in the lowest bits, as on the bus
   typedef logic [NUM_COLS-1:0][FIELD_W-1:0] vec_type;
   // m[row][col]
   typedef logic [NUM_ROWS-1:0][NUM_COLS-1:0][FIELD_W-1:0] matrix_type;

   typedef struct packed {
      logic                             saturated;
      logic [NUM_ROWS-1:0][FIELD_W-1:0] comp;
   } xform_out_type;

   typedef enum {MAT_SMALL, MAT_MIXED, MAT_FULL} fill_mode_type;

   // -------------------------------------------------------------------------
   // transform predictor and response checker
   // -------------------------------------------------------------------------
   class xform_scoreboard;
      logic [REG_W-1:0] matrix_regs [REG_COUNT];
      xform_out_type    expected_outputs [$];
      string            comp_name [NUM_ROWS] = '{"x", "y", "z", "w"};
      int               error_count      = 0;
      int               checked_count    = 0;
      int               saturation_count = 0;

      // identity, as after reset
      function void load_identity();
         for (int i = 0; i < REG_COUNT; i++) matrix_regs[i] = '0;
         for (int r = 0; r < NUM_ROWS; r++) begin
            if (r % 2 == 1)
               matrix_regs[r*2 + r/2][2*FIELD_W-1:FIELD_W] = Q_ONE;
            else
               matrix_regs[r*2 + r/2][FIELD_W-1:0] = Q_ONE;
         end
      endfunction

      function void write_register(reg_idx_type idx, logic [REG_W-1:0] value);
         matrix_regs[idx] = value;
      endfunction

      function logic [FIELD_W-1:0] element(int r, int c);
         logic [REG_W-1:0] word;
         word = matrix_regs[r*2 + c/2];
         return (c % 2 == 1) ? word[2*FIELD_W-1:FIELD_W] : word[FIELD_W-1:0];
      endfunction

      // exact dot products, floor shift, clip
      function xform_out_type transform(vec_type v);
         xform_out_type               res;
         logic signed [FIELD_W-1:0]   a;
         logic signed [FIELD_W-1:0]   b;
         logic signed [2*FIELD_W-1:0] prod;
         logic signed [SUM_W-1:0]     acc;
         logic signed [SUM_W-1:0]     scaled;
         res = '0;
         for (int r = 0; r < NUM_ROWS; r++) begin
            acc = '0;
            for (int c = 0; c < NUM_COLS; c++) begin
               a    = element(r, c);
               b    = v[c];
               prod = a * b;
               acc  = acc + prod;
            end
            scaled = acc >>> FRAC_BITS;
            if (scaled > COMP_MAX) begin
               res.comp[r]   = FIELD_MAX;
               res.saturated = 1'b1;
            end else if (scaled < COMP_MIN) begin
               res.comp[r]   = FIELD_MIN;
               res.saturated = 1'b1;
            end else begin
               res.comp[r] = scaled[FIELD_W-1:0];
            end
         end
         return res;
      endfunction

      function void note_request(vec_type v);
         expected_outputs.push_back(transform(v));
      endfunction

      function void check_response(logic [NUM_ROWS*FIELD_W-1:0] data, logic sat);
         xform_out_type exp_out;
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected response data=%h sat=%b", $time, data, sat);
            error_count++;
            return;
         end
         exp_out = expected_outputs.pop_front();
         checked_count++;
         if (exp_out.saturated) saturation_count++;
         for (int r = 0; r < NUM_ROWS; r++) begin
            if (data[r*FIELD_W +: FIELD_W] !== exp_out.comp[r]) begin
               $display("%0t: out_%s mismatch expected=%h actual=%h", $time,
                        comp_name[r], exp_out.comp[r], data[r*FIELD_W +: FIELD_W]);
               error_count++;
            end
         end
         if (sat !== exp_out.saturated) begin
            $display("%0t: saturated mismatch expected=%b actual=%b", $time,
                     exp_out.saturated, sat);
            error_count++;
         end
      endfunction

      function int pending();
         return expected_outputs.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // signals and block
   // -------------------------------------------------------------------------
   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [NUM_COLS*FIELD_W-1:0] req_tdata;   // vec_x, vec_y, vec_z, vec_w
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [NUM_ROWS*FIELD_W-1:0] rsp_tdata;   // out_x, out_y, out_z, out_w
   logic                        rsp_tuser;   // saturated
   logic                        csr_we;
   logic [REG_IDX_W-1:0]        csr_addr;
   logic [REG_W-1:0]            csr_wdata;

   xform_scoreboard sb = new();
   vec_type         vec_queue [$];
   bit              idle_enabled      = 1'b0;
   bit              long_hold_pending = 1'b0;
   int              settings_count    = 0;
   int              cycle_count       = 0;

   matrix_vector_transform #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run stopped at the cycle limit, %0d responses still due",
                  $time, sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // helpers
   // -------------------------------------------------------------------------

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_enabled || roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic vec_type vec4(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                    logic [FIELD_W-1:0] z, logic [FIELD_W-1:0] w);
      return {w, z, y, x};
   endfunction

   function automatic matrix_type fill_matrix(logic [FIELD_W-1:0] value);
      matrix_type m;
      for (int r = 0; r < NUM_ROWS; r++)
         for (int c = 0; c < NUM_COLS; c++) m[r][c] = value;
      return m;
   endfunction

   // extremes, zero, full random, or a moderate value within +-32.0
   function automatic logic [FIELD_W-1:0] random_component();
      logic [21:0] s;
      s = 22'($urandom());
      case ($urandom_range(0, 9))
         0:       return FIELD_MAX;
         1:       return FIELD_MIN;
         2:       return '0;
         3, 4, 5: return $urandom();
         default: return {{10{s[21]}}, s};
      endcase
   endfunction

   function automatic logic [FIELD_W-1:0] random_element(fill_mode_type mode);
      logic [19:0] s;
      s = 20'($urandom());
      case (mode)
         MAT_SMALL: return {{12{s[19]}}, s};
         MAT_FULL:  return $urandom();
         default: begin
            case ($urandom_range(0, 5))
               0:       return FIELD_MAX;
               1:       return FIELD_MIN;
               2:       return '0;
               default: return {{12{s[19]}}, s};
            endcase
         end
      endcase
   endfunction

   // write all eight matrix registers back to back
   task automatic load_matrix(input matrix_type m);
      reg_idx_type      idx;
      logic [REG_W-1:0] value;
      idx = idx.first();
      do begin
         value = {m[idx/2][(idx%2)*2 + 1], m[idx/2][(idx%2)*2]};
         csr_we    <= 1'b1;
         csr_addr  <= idx;
         csr_wdata <= value;
         sb.write_register(idx, value);
         @(posedge clock);
         idx = idx.next();
      end while (idx != idx.first());
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // one request; returns at the edge where it was taken
   task automatic send_vector(input vec_type v);
      int gap;
      bit taken;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         if (taken) sb.note_request(v);
         @(posedge clock);
      end
   endtask

   // send the queued vectors, then wait until all responses are back
   task automatic flush_vectors(input int hold_at);
      int n;
      n = 0;
      while (vec_queue.size() != 0) begin
         if (n == hold_at) long_hold_pending = 1'b1;
         send_vector(vec_queue.pop_front());
         n++;
      end
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // response side: random stalls plus one long hold, check at each transfer
   // -------------------------------------------------------------------------
   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            if (long_hold_pending) begin
               stall_left        = HOLD_CYCLES;
               long_hold_pending = 1'b0;
            end else begin
               stall_left = pick_gap();
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(negedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // -------------------------------------------------------------------------
   // stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      matrix_type    m;
      fill_mode_type mode;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= REG_ROW0_COLS01;
      csr_wdata  <= '0;
      sb.load_identity();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity after reset: values pass through unchanged
      vec_queue.push_back(vec4('0, '0, '0, '0));
      vec_queue.push_back(vec4(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
      vec_queue.push_back(vec4(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
      vec_queue.push_back(vec4('1, '1, '1, '1));
      vec_queue.push_back(vec4(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
      vec_queue.push_back(vec4(32'd1, '1, FIELD_MAX, FIELD_MIN));
      flush_vectors(-1);

      // every element most negative: sums beyond 64 bits, both signs
      load_matrix(fill_matrix(FIELD_MIN));
      vec_queue.push_back(vec4(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
      vec_queue.push_back(vec4(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
      vec_queue.push_back(vec4(32'd1, '0, '0, '0));
      vec_queue.push_back(vec4(FIELD_MIN, FIELD_MAX, '0, '1));
      flush_vectors(-1);

      // every element most positive
      load_matrix(fill_matrix(FIELD_MAX));
      vec_queue.push_back(vec4(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX));
      vec_queue.push_back(vec4(FIELD_MIN, FIELD_MIN, FIELD_MIN, FIELD_MIN));
      vec_queue.push_back(vec4(FIELD_MAX, FIELD_MIN, FIELD_MAX, FIELD_MIN));
      vec_queue.push_back(vec4(32'd1, 32'd1, 32'd1, 32'd1));
      flush_vectors(-1);

      // clip edges on both sides and flooring of negative halves
      m = fill_matrix('0);
      m[0][0] = Q_TWO;
      m[1][0] = -Q_TWO;
      m[2]    = {Q_HALF, Q_HALF, Q_HALF, Q_HALF};
      m[3][0] = -Q_HALF;
      load_matrix(m);
      vec_queue.push_back(vec4(32'h3FFF_FFFF, 32'd1, 32'd1, 32'd1));
      vec_queue.push_back(vec4(32'h4000_0000, 32'd1, 32'd1, 32'd1));
      vec_queue.push_back(vec4(32'hC000_0000, 32'd1, 32'd1, 32'd1));
      vec_queue.push_back(vec4(32'hBFFF_FFFF, 32'd1, 32'd1, 32'd1));
      vec_queue.push_back(vec4(32'd1, '0, '0, '0));
      vec_queue.push_back(vec4('1, '1, '1, '1));
      flush_vectors(-1);

      // random matrices and vectors; some phases run without gaps
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 3)
            0:       mode = MAT_SMALL;
            1:       mode = MAT_MIXED;
            default: mode = MAT_FULL;
         endcase
         for (int r = 0; r < NUM_ROWS; r++)
            for (int c = 0; c < NUM_COLS; c++) m[r][c] = random_element(mode);
         load_matrix(m);
         idle_enabled = (p % 4 != 1);
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            vec_queue.push_back(vec4(random_component(), random_component(),
                                     random_component(), random_component()));
         flush_vectors((p == HOLD_PHASE) ? HOLD_AT_ITEM : -1);
      end

      // drain and watch for strays
      idle_enabled = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2*LATENCY) @(posedge clock);

      $display("Checked %0d transforms over %0d matrix settings plus identity,",
               sb.checked_count, settings_count);
      $display("%0d of them clipped, with random gaps and a %0d-cycle response hold.",
               sb.saturation_count, HOLD_CYCLES);
      if (sb.error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
